/* rtl/x86_branch_address_converter_macros.svh */
// Assertion macros shared by the x86 branch address converter RTL.
// Included by the modules that carry concurrent assertions.
`ifndef X86_BRANCH_ADDRESS_CONVERTER_MACROS_SVH
`define X86_BRANCH_ADDRESS_CONVERTER_MACROS_SVH

`ifndef SYNTH
`define XBAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define XBAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define XBAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define XBAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/xbac_pkg.sv */
// Package for the x86 branch address converter: job type, opcodes and
// configuration register indexes. No dependencies.
package xbac_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODE           = 2'd0;
  localparam cfg_idx_t REG_START_POSITION = 2'd1;

  localparam logic [7:0] OP_CALL     = 8'hE8;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] OP_ESCAPE   = 8'h0F;
  localparam logic [3:0] OP_JCC_HIGH = 4'h8;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_ONES   = 8'hFF;

  localparam logic MODE_ENCODE = 1'b0;

  typedef struct packed {
    logic            is_run;
    logic            mode;
    logic [31:0]     position;
    logic [4:0][7:0] bytes;
  } job_t;

endpackage

/* rtl/xbac_front.sv */
// Front end: accepts bytes, tracks position, detects branch opcodes and
// captures five-byte runs into jobs. Depends on xbac_pkg.
module xbac_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_byte,
  output logic              in_full,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  xbac_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              q_push,
  output xbac_pkg::job_t    q_job,
  input  logic              q_full
);
  import xbac_pkg::*;

  logic            mode_r;
  logic [31:0]     position_r;
  logic            capturing_r, capturing_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic [3:0][7:0] cap_r;
  logic            accept;
  logic            trig;
  logic            run_done;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;

  always_comb begin
    trig = (in_byte == OP_CALL) || (in_byte == OP_JMP) ||
           ((prev_r == OP_ESCAPE) && (in_byte[7:4] == OP_JCC_HIGH));
    run_done      = 1'b0;
    capturing_nxt = capturing_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    q_push        = 1'b0;
    if (accept) begin
      if (!capturing_r) begin
        prev_nxt = in_byte;
        if (trig) begin
          capturing_nxt = 1'b1;
          cnt_nxt       = 3'd1;
        end else begin
          q_push = 1'b1;
        end
      end else if (cnt_r == 3'd4) begin
        run_done      = 1'b1;
        q_push        = 1'b1;
        capturing_nxt = 1'b0;
        cnt_nxt       = 3'd0;
        prev_nxt      = BYTE_ZERO;
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
    q_job.is_run   = run_done;
    q_job.mode     = mode_r;
    q_job.position = position_r;
    q_job.bytes[0] = run_done ? cap_r[0] : in_byte;
    q_job.bytes[1] = cap_r[1];
    q_job.bytes[2] = cap_r[2];
    q_job.bytes[3] = cap_r[3];
    q_job.bytes[4] = in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ENCODE;
      position_r  <= '0;
      capturing_r <= 1'b0;
      cnt_r       <= 3'd0;
      prev_r      <= BYTE_ZERO;
    end else begin
      capturing_r <= capturing_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      if (cfg_valid && (cfg_index == REG_START_POSITION)) begin
        position_r <= cfg_data;
      end else if (accept) begin
        position_r <= position_r + 32'd1;
      end
      if (cfg_valid && (cfg_index == REG_MODE)) begin
        mode_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !capturing_r && trig) begin
      cap_r[0] <= in_byte;
    end else if (accept && capturing_r && (cnt_r != 3'd4)) begin
      cap_r[cnt_r[1:0]] <= in_byte;
    end
  end

endmodule

/* rtl/xbac_queue.sv */
// Job queue between the front end and the back end.
// Depends on xbac_pkg for the job type.
module xbac_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xbac_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output xbac_pkg::job_t pop_job,
  output logic           empty
);
  import xbac_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/xbac_back.sv */
// Back end: converts branch displacements and emits one byte per cycle while out_pop is high.
// Depends on xbac_pkg and the assertion macro header.
`include "x86_branch_address_converter_macros.svh"
module xbac_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  xbac_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_empty,
  output logic [7:0]     out_byte,
  output logic           out_last,
  input  logic           out_pop
);
  import xbac_pkg::*;

  logic            cur_valid_r;
  logic            run_r;
  logic [2:0]      idx_r;
  logic [4:0][7:0] cur_bytes_r;
  logic [4:0][7:0] conv_bytes;
  logic [31:0]     word_enc, word_dec, sum;
  logic            do_conv;
  logic            load;

  assign out_empty = !cur_valid_r;
  assign out_byte  = cur_bytes_r[idx_r];
  assign out_last  = !run_r || (idx_r == 3'd4);
  assign load      = !q_empty && (!cur_valid_r || (out_pop && out_last));
  assign q_pop     = load;

  always_comb begin
    word_enc = {q_job.bytes[4], q_job.bytes[3], q_job.bytes[2], q_job.bytes[1]};
    word_dec = {q_job.bytes[4], q_job.bytes[2], q_job.bytes[3], q_job.bytes[1]};
    sum = (q_job.mode == MODE_ENCODE) ? word_enc + q_job.position
                                      : word_dec - q_job.position;
    do_conv = q_job.is_run &&
              ((q_job.bytes[4] == BYTE_ZERO) || (q_job.bytes[4] == BYTE_ONES));
    conv_bytes = q_job.bytes;
    if (do_conv) begin
      conv_bytes[1] = sum[7:0];
      if (q_job.mode == MODE_ENCODE) begin
        conv_bytes[2] = sum[23:16];
        conv_bytes[3] = sum[15:8];
      end else begin
        conv_bytes[2] = sum[15:8];
        conv_bytes[3] = sum[23:16];
      end
      conv_bytes[4] = sum[24] ? BYTE_ONES : BYTE_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (load) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 3'd0;
    end else if (cur_valid_r && out_pop) begin
      if (out_last) begin
        cur_valid_r <= 1'b0;
        idx_r       <= 3'd0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r       <= q_job.is_run;
      cur_bytes_r <= conv_bytes;
    end
  end

  `XBAC_ASSERT_IMP(a_single_at_zero, clk, rst_n, cur_valid_r && !run_r, idx_r == 3'd0)
  `XBAC_ASSERT_NXT(a_step_in_run, clk, rst_n, cur_valid_r && out_pop && !out_last, cur_valid_r && (idx_r == $past(idx_r) + 3'd1))
  `XBAC_ASSERT_NXT(a_load_when_free, clk, rst_n, !cur_valid_r && !q_empty, cur_valid_r && (idx_r == 3'd0))

endmodule

/* rtl/x86_branch_address_converter.sv */
// Top level of the x86 branch address converter: front end, job queue and
// back end. Depends on xbac_pkg, xbac_front, xbac_queue and xbac_back.
//
// Filters an x86 code byte stream for a compressor: E8/E9 calls and jumps and
// 0F 8x conditional jumps have their 32-bit displacement made absolute (mode 0)
// or relative again (mode 1) when its top byte is 00 or FF. The input takes one
// byte per cycle while in_full is low; when the output side is free, a plain
// byte reaches the output through the job queue and the back end's register,
// and a branch emits five bytes, one per cycle while out_pop stays high, once
// its fifth byte is taken. The back end sends at most one byte per cycle, so
// runs of five are absorbed by a job queue of QUEUE_DEPTH entries and in_full
// rises only when that queue fills. Writing start_position reloads the
// running position; write configuration only while the block is idle.
module x86_branch_address_converter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [7:0]         in_byte,
  output logic               in_full,
  output logic               out_empty,
  output logic [7:0]         out_byte,
  output logic               out_last,
  input  logic               out_pop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  xbac_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]        cfg_data
);
  import xbac_pkg::*;

  job_t push_job, pop_job;
  logic q_push, q_full, q_pop, q_empty;

  xbac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_byte   (in_byte),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_job     (push_job),
    .q_full    (q_full)
  );

  xbac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  xbac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_pop   (out_pop)
  );

endmodule

/* sim/x86_branch_address_converter_tb.sv */
// Testbench for x86_branch_address_converter: drives byte streams through the
// queue-style ports and checks every output byte against a built-in predictor.
// Depends on xbac_pkg and the converter RTL.
module x86_branch_address_converter_tb;
  import xbac_pkg::*;

  localparam cfg_idx_t REG_SPARE_A = 2'd2;
  localparam cfg_idx_t REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS = 25;

  class branch_filter_scoreboard;
    typedef struct {
      logic [7:0] value;
      logic       last;
    } filtered_byte_t;

    filtered_byte_t pending_bytes[$];
    logic           mode;
    logic [31:0]    running_pos;
    logic [7:0]     run_bytes[5];
    int             run_fill;
    bit             in_run;
    logic [7:0]     last_idle_byte;
    int             errors;
    int             bytes_in;
    int             bytes_out;
    int             runs_converted;

    function new();
      mode = MODE_ENCODE;
      running_pos = 32'd0;
      run_fill = 0;
      in_run = 1'b0;
      last_idle_byte = BYTE_ZERO;
      errors = 0;
      bytes_in = 0;
      bytes_out = 0;
      runs_converted = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_MODE: mode = data[0];
        REG_START_POSITION: running_pos = data;
        default: ;
      endcase
    endfunction

    // Predicts the output bytes caused by one accepted input byte.
    function void accept_byte(logic [7:0] b);
      logic [31:0]    word;
      filtered_byte_t entry;
      bytes_in++;
      if (!in_run) begin
        if (b == OP_CALL || b == OP_JMP ||
            (last_idle_byte == OP_ESCAPE && b[7:4] == OP_JCC_HIGH)) begin
          in_run = 1'b1;
        end
        last_idle_byte = b;
      end
      if (in_run) begin
        run_bytes[run_fill] = b;
        run_fill++;
        if (run_fill == 5) begin
          run_fill = 0;
          in_run = 1'b0;
          last_idle_byte = BYTE_ZERO;
          if (run_bytes[4] == BYTE_ZERO || run_bytes[4] == BYTE_ONES) begin
            runs_converted++;
            if (mode == MODE_ENCODE) begin
              word = {run_bytes[4], run_bytes[3], run_bytes[2], run_bytes[1]} + running_pos;
              run_bytes[1] = word[7:0];
              run_bytes[2] = word[23:16];
              run_bytes[3] = word[15:8];
            end else begin
              word = {run_bytes[4], run_bytes[2], run_bytes[3], run_bytes[1]} - running_pos;
              run_bytes[1] = word[7:0];
              run_bytes[2] = word[15:8];
              run_bytes[3] = word[23:16];
            end
            run_bytes[4] = word[24] ? BYTE_ONES : BYTE_ZERO;
          end
          for (int i = 0; i < 5; i++) begin
            entry.value = run_bytes[i];
            entry.last = (i == 4);
            pending_bytes.push_back(entry);
          end
        end
      end else begin
        entry.value = b;
        entry.last = 1'b1;
        pending_bytes.push_back(entry);
      end
      running_pos++;
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      filtered_byte_t entry;
      bytes_out++;
      if (pending_bytes.size() == 0) begin
        $error("out_byte: no byte expected, actual %h (out_last %b)", value, last);
        errors++;
      end else begin
        entry = pending_bytes.pop_front();
        if (value !== entry.value) begin
          $error("out_byte: expected %h, actual %h", entry.value, value);
          errors++;
        end
        if (last !== entry.last) begin
          $error("out_last: expected %b, actual %b", entry.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic [7:0]  in_byte;
  logic        in_full;
  logic        out_empty;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_pop;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_data;

  bit quiet_phase = 1'b0;
  int items_sent = 0;
  branch_filter_scoreboard sb = new();

  logic [7:0] branch_samples [24] = '{
    8'hE8, 8'h12, 8'h34, 8'h56, 8'h00,
    8'hE9, 8'hAB, 8'hCD, 8'hEF, 8'hFF,
    8'h0F, 8'h85, 8'h01, 8'h02, 8'h03, 8'h00,
    8'h0F, 8'h7F,
    8'hE8, 8'h11, 8'h22, 8'h33, 8'h0F,
    8'h8F
  };

  x86_branch_address_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_byte   (in_byte),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_pop   (out_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      sb.check_byte(out_byte, out_last);
    end
  end

  initial begin
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic set_reg(cfg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_byte(logic [7:0] b);
    if (!quiet_phase && $urandom_range(0, 11) == 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_full);
    sb.accept_byte(b);
    items_sent++;
  endtask

  // Mostly well-formed branches with random displacements, the rest noise.
  // A run left open at the end is completed so the block ends up idle.
  task automatic send_random_bytes(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 2))
          0: push_byte(OP_CALL);
          1: push_byte(OP_JMP);
          default: begin
            push_byte(OP_ESCAPE);
            push_byte({OP_JCC_HIGH, 4'($urandom())});
          end
        endcase
        repeat (3) push_byte(8'($urandom()));
        if ($urandom_range(0, 9) < 8) begin
          push_byte($urandom_range(0, 1) ? BYTE_ONES : BYTE_ZERO);
        end else begin
          push_byte(8'($urandom()));
        end
      end else if ($urandom_range(0, 3) == 0) begin
        push_byte(OP_ESCAPE);
      end else begin
        push_byte(8'($urandom()));
      end
    end
    while (sb.in_run) push_byte(8'($urandom()));
  endtask

  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = 32'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_reg(REG_MODE, {31'h7FFF_FFFF, MODE_ENCODE});
    set_reg(REG_START_POSITION, 32'hFFFF_FFFC);
    set_reg(REG_SPARE_A, $urandom());
    set_reg(REG_SPARE_B, $urandom());
    foreach (branch_samples[i]) push_byte(branch_samples[i]);
    settle();

    set_reg(REG_MODE, {31'($urandom()), ~MODE_ENCODE});
    set_reg(REG_START_POSITION, 32'd0);
    send_random_bytes(PHASE_ITEMS);
    settle();

    set_reg(REG_MODE, {31'($urandom()), MODE_ENCODE});
    set_reg(REG_START_POSITION, 32'hFFFF_FFFF);
    send_random_bytes(PHASE_ITEMS);
    settle();

    set_reg(REG_MODE, {31'($urandom()), ~MODE_ENCODE});
    set_reg(REG_START_POSITION, $urandom());
    send_random_bytes(PHASE_ITEMS);
    settle();

    quiet_phase = 1'b1;
    set_reg(REG_MODE, {31'($urandom()), MODE_ENCODE});
    set_reg(REG_START_POSITION, $urandom());
    send_random_bytes(PHASE_ITEMS);
    settle();

    if (sb.pending_bytes.size() != 0) begin
      $error("out_byte: %0d expected bytes never arrived", sb.pending_bytes.size());
      sb.errors++;
    end
    $display("Sent %0d bytes and checked %0d filtered bytes in encode and decode modes,",
             sb.bytes_in, sb.bytes_out);
    $display("including %0d branch runs whose displacement was converted.",
             sb.runs_converted);
    if (sb.errors == 0) begin
      $display("** x86_branch_address_converter: PASSED **");
    end else begin
      $display("** x86_branch_address_converter: FAILED **");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("** x86_branch_address_converter: FAILED **");
    $finish;
  end

endmodule
